FILE: hdl/fwd_pkg.sv
// ----------------------------------------------------------------------------
// fwd_pkg: shared definitions for the word delta decoder
// Field widths and default values used by the channel interfaces and the
// decoder top level.
// ----------------------------------------------------------------------------
package fwd_pkg;

	localparam int BYTE_W  = 8;
	localparam int WORD_W  = 16;
	localparam int ADDR_W  = 20;
	localparam int REP_W   = 8;
	localparam int PITCH_W = 12;

	localparam logic [PITCH_W-1:0] PITCH_RESET = 12'd320;

	localparam int FRAME_BYTES_DEF = 1048576;

endpackage

FILE: hdl/fwd_chunk_if.sv
// ----------------------------------------------------------------------------
// fwd_chunk_if: chunk byte channel
// Carries one payload byte and its chunk start mark per transaction.
// ----------------------------------------------------------------------------
interface fwd_chunk_if;

	logic                        valid;
	logic                        ready;
	logic [fwd_pkg::BYTE_W-1:0]  chunk_byte;
	logic                        chunk_start;

	modport source (output valid, output chunk_byte, output chunk_start, input ready);
	modport sink   (input valid, input chunk_byte, input chunk_start, output ready);

endinterface

FILE: hdl/fwd_write_if.sv
// ----------------------------------------------------------------------------
// fwd_write_if: frame-buffer write command channel
// Carries one write command (address, word, repeat, overrun flag).
// ----------------------------------------------------------------------------
interface fwd_write_if;

	logic                        valid;
	logic                        ready;
	logic [fwd_pkg::ADDR_W-1:0]  write_address;
	logic [fwd_pkg::WORD_W-1:0]  pixel_pair;
	logic [fwd_pkg::REP_W-1:0]   word_repeat;
	logic                        beyond_frame;

	modport source (output valid, output write_address, output pixel_pair,
		output word_repeat, output beyond_frame, input ready);
	modport sink   (input valid, input write_address, input pixel_pair,
		input word_repeat, input beyond_frame, output ready);

endinterface

FILE: hdl/fwd_cfg_if.sv
// ----------------------------------------------------------------------------
// fwd_cfg_if: configuration write channel
// Carries a new value of the line pitch register per transaction.
// ----------------------------------------------------------------------------
interface fwd_cfg_if;

	logic                         valid;
	logic                         ready;
	logic [fwd_pkg::PITCH_W-1:0]  line_pitch;

	modport source (output valid, output line_pitch, input ready);
	modport sink   (input valid, input line_pitch, output ready);

endinterface

FILE: hdl/flic_word_delta_decoder_top.sv
// ----------------------------------------------------------------------------
// flic_word_delta_decoder_top: word-oriented FLC delta chunk decoder
// Parses the delta chunk payload byte by byte and emits frame-buffer writes.
// ----------------------------------------------------------------------------
// Usage:
// The chunk channel takes one payload byte per transaction; chunk_start set
// on the first byte of a chunk clears the parser, row and column before that
// byte is parsed. The write channel delivers one command per literal word or
// per run of repeated words: byte address row * line_pitch + column (low 20
// bits), the word, its repeat count and a flag when the write runs past the
// frame store. The config channel writes line_pitch; it is always ready and
// must only be used while no byte is in flight.
// Every byte is parsed in the cycle it is accepted, so one byte is taken per
// cycle while the first stage can load. A write caused by a byte then passes
// three registered stages: parse stage, multiply stage (row times pitch), then
// the address add and overrun compare into the output register.
// Each stage holds its item while the next stage is full, so a stalled
// receiver only blocks the chunk channel once all three stages are occupied.
// Reset clears the parser to wait for the line count, empties the pipeline
// and sets line_pitch to 320.
// ----------------------------------------------------------------------------
module flic_word_delta_decoder_top #(
	parameter int FRAME_BYTES = fwd_pkg::FRAME_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	fwd_chunk_if.sink     chunk,
	fwd_cfg_if.sink       cfg,
	fwd_write_if.source   wr
);

	localparam int BW = fwd_pkg::BYTE_W;
	localparam int WW = fwd_pkg::WORD_W;
	localparam int RW = fwd_pkg::REP_W;
	localparam int PW = fwd_pkg::PITCH_W;
	localparam int AW = fwd_pkg::ADDR_W;

	// Product of a 16-bit row and the pitch, then room for column and run.
	localparam int PROD_W  = WW + PW;
	localparam int SUM_W   = PROD_W + 1;
	localparam int FRAME_W = $clog2(FRAME_BYTES + 1);
	localparam int CMP_W   = (SUM_W > FRAME_W) ? SUM_W : FRAME_W;
	localparam logic [CMP_W-1:0] FRAME_LIMIT = CMP_W'(FRAME_BYTES);

	// Parser phases.
	localparam logic [3:0] PH_LINES_LO = 4'd0;
	localparam logic [3:0] PH_LINES_HI = 4'd1;
	localparam logic [3:0] PH_OP_LO    = 4'd2;
	localparam logic [3:0] PH_OP_HI    = 4'd3;
	localparam logic [3:0] PH_SKIP     = 4'd4;
	localparam logic [3:0] PH_COUNT    = 4'd5;
	localparam logic [3:0] PH_LIT_LO   = 4'd6;
	localparam logic [3:0] PH_LIT_HI   = 4'd7;
	localparam logic [3:0] PH_REP_LO   = 4'd8;
	localparam logic [3:0] PH_REP_HI   = 4'd9;
	localparam logic [3:0] PH_IDLE     = 4'd10;

	// Configuration register. Writes are always taken.
	logic [PW-1:0] pitch_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= fwd_pkg::PITCH_RESET;
		end else if (cfg.valid) begin
			pitch_q <= cfg.line_pitch;
		end
	end

	// Parser state.
	logic [3:0]    phase_q;
	logic [15:0]   lines_q;
	logic [13:0]   packets_q;
	logic [15:0]   column_q;
	logic [15:0]   row_q;
	logic [6:0]    literal_q;
	logic [RW-1:0] repeat_q;
	logic [BW-1:0] held_q;

	logic [3:0]    phase_d;
	logic [15:0]   lines_d;
	logic [13:0]   packets_d;
	logic [15:0]   column_d;
	logic [15:0]   row_d;
	logic [6:0]    literal_d;
	logic [RW-1:0] repeat_d;
	logic [BW-1:0] held_d;

	// Write request produced by the current byte.
	logic          emit;
	logic [15:0]   emit_row;
	logic [15:0]   emit_column;
	logic [WW-1:0] emit_word;
	logic [RW-1:0] emit_reps;

	// Pipeline stages: s1 parse result, s2 product, output register.
	logic          v_s1;
	logic [15:0]   row_s1;
	logic [15:0]   column_s1;
	logic [WW-1:0] word_s1;
	logic [RW-1:0] reps_s1;

	logic          v_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [15:0]   column_s2;
	logic [WW-1:0] word_s2;
	logic [RW-1:0] reps_s2;

	logic          v_out_q;
	logic          load_out;
	logic          load_s2;
	logic          load_s1;
	logic          take;

	assign load_out = !v_out_q || wr.ready;
	assign load_s2  = !v_s2 || load_out;
	assign load_s1  = !v_s1 || load_s2;

	assign chunk.ready = load_s1;
	assign take        = chunk.valid && load_s1;

	// Parse one byte: clear on chunk start, then step the phase.
	always_comb begin
		logic [3:0]    ph;
		logic [15:0]   ln;
		logic [13:0]   pk;
		logic [15:0]   col;
		logic [15:0]   rw;
		logic [6:0]    lit;
		logic [RW-1:0] rep;
		logic [BW-1:0] held;
		logic [WW-1:0] w;
		logic [BW-1:0] b;
		logic          end_pkt;
		logic          end_ln;

		b = chunk.chunk_byte;
		if (chunk.chunk_start) begin
			ph   = PH_LINES_LO;
			ln   = '0;
			pk   = '0;
			col  = '0;
			rw   = '0;
			lit  = '0;
			rep  = '0;
			held = '0;
		end else begin
			ph   = phase_q;
			ln   = lines_q;
			pk   = packets_q;
			col  = column_q;
			rw   = row_q;
			lit  = literal_q;
			rep  = repeat_q;
			held = held_q;
		end

		w           = {b, held};
		emit        = 1'b0;
		emit_row    = rw;
		emit_column = col;
		emit_word   = w;
		emit_reps   = RW'(1);
		end_pkt     = 1'b0;
		end_ln      = 1'b0;

		unique case (ph)
			PH_LINES_LO, PH_OP_LO, PH_LIT_LO, PH_REP_LO: begin
				held = b;
				ph   = ph + 4'd1;
			end
			PH_LINES_HI: begin
				if (w == '0 || w[15]) begin
					ln = '0;
					ph = PH_IDLE;
				end else begin
					ln  = w;
					col = '0;
					ph  = PH_OP_LO;
				end
			end
			PH_OP_HI: begin
				if (w[15] && w[14]) begin
					// Line skip: the opcode is minus the number of lines.
					rw = rw - w;
					ph = PH_OP_LO;
				end else if (w[15] || w[14]) begin
					ph = PH_OP_LO;
				end else if (w == '0) begin
					end_ln = 1'b1;
				end else begin
					pk = w[13:0];
					ph = PH_SKIP;
				end
			end
			PH_SKIP: begin
				col = col + 16'(b);
				ph  = PH_COUNT;
			end
			PH_COUNT: begin
				if (b == '0) begin
					end_pkt = 1'b1;
				end else if (b[7]) begin
					rep = RW'(~b + 8'd1);
					ph  = PH_REP_LO;
				end else begin
					lit = b[6:0];
					ph  = PH_LIT_LO;
				end
			end
			PH_LIT_HI: begin
				emit = 1'b1;
				col  = col + 16'd2;
				lit  = lit - 7'd1;
				if (lit == '0) begin
					end_pkt = 1'b1;
				end else begin
					ph = PH_LIT_LO;
				end
			end
			PH_REP_HI: begin
				emit      = 1'b1;
				emit_reps = rep;
				col       = col + {7'd0, rep, 1'b0};
				rep       = '0;
				end_pkt   = 1'b1;
			end
			default: begin
				ph = PH_IDLE;
			end
		endcase

		if (end_pkt) begin
			pk = pk - 14'd1;
			if (pk == '0) begin
				end_ln = 1'b1;
			end else begin
				ph = PH_SKIP;
			end
		end
		if (end_ln) begin
			rw  = rw + 16'd1;
			col = '0;
			ln  = ln - 16'd1;
			ph  = (ln == '0) ? PH_IDLE : PH_OP_LO;
		end

		phase_d   = ph;
		lines_d   = ln;
		packets_d = pk;
		column_d  = col;
		row_d     = rw;
		literal_d = lit;
		repeat_d  = rep;
		held_d    = held;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LINES_LO;
			lines_q   <= '0;
			packets_q <= '0;
			column_q  <= '0;
			row_q     <= '0;
			literal_q <= '0;
			repeat_q  <= '0;
			held_q    <= '0;
		end else if (take) begin
			phase_q   <= phase_d;
			lines_q   <= lines_d;
			packets_q <= packets_d;
			column_q  <= column_d;
			row_q     <= row_d;
			literal_q <= literal_d;
			repeat_q  <= repeat_d;
			held_q    <= held_d;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1 <= take && emit;
			end
			if (load_s2) begin
				v_s2 <= v_s1;
			end
			if (load_out) begin
				v_out_q <= v_s2;
			end
		end
	end

	// Stage payloads carry no reset.
	logic [SUM_W-1:0] addr_full;
	logic [CMP_W-1:0] addr_end;

	assign addr_full = {1'b0, prod_s2} + SUM_W'(column_s2);
	assign addr_end  = CMP_W'(addr_full) + CMP_W'({reps_s2, 1'b0});

	always_ff @(posedge clk) begin
		if (load_s1) begin
			row_s1    <= emit_row;
			column_s1 <= emit_column;
			word_s1   <= emit_word;
			reps_s1   <= emit_reps;
		end
		if (load_s2) begin
			prod_s2   <= PROD_W'(row_s1 * pitch_q);
			column_s2 <= column_s1;
			word_s2   <= word_s1;
			reps_s2   <= reps_s1;
		end
		if (load_out) begin
			wr.write_address <= addr_full[AW-1:0];
			wr.pixel_pair    <= word_s2;
			wr.word_repeat   <= reps_s2;
			wr.beyond_frame  <= addr_end > FRAME_LIMIT;
		end
	end

	assign wr.valid = v_out_q;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for flic_word_delta_decoder_top
// Streams delta chunk payload bytes into the decoder and checks every write
// command against an in-bench model of the parser. A directed table runs first,
// then random chunks under several line pitch settings with random idling.
// ----------------------------------------------------------------------------
module tb;

	// Clock period is 10 ns; reset is held at the start of the run.
	localparam int RESET_CYCLES  = 6;
	// The write passes the parse, multiply and output registers after its byte;
	// the settle time before a pitch change covers that with margin.
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int PHASE_BYTES   = 140;
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_REPORTS   = 10;
	localparam int NUM_PHASES    = 6;
	localparam int DIRECTED_ROWS = 25;
	localparam longint FRAME_LIMIT = fwd_pkg::FRAME_BYTES_DEF;

	// Opcode classes, decided by the top two bits of an opcode word.
	localparam logic [fwd_pkg::WORD_W-1:0] OP_CLASS_MASK = 16'hC000;
	localparam logic [fwd_pkg::WORD_W-1:0] OP_LINE_SKIP  = 16'hC000;
	localparam logic [fwd_pkg::WORD_W-1:0] OP_IGNORED_LO = 16'h4000;
	localparam logic [fwd_pkg::WORD_W-1:0] OP_IGNORED_HI = 16'h8000;

	// Parser phases of the model; one per byte position in the grammar.
	typedef enum logic [3:0] {
		WAIT_LINES_LO,
		WAIT_LINES_HI,
		WAIT_OP_LO,
		WAIT_OP_HI,
		WAIT_SKIP,
		WAIT_COUNT,
		WAIT_LIT_LO,
		WAIT_LIT_HI,
		WAIT_REP_LO,
		WAIT_REP_HI,
		PARSE_IDLE
	} parse_phase_t;

	typedef struct packed {
		logic [fwd_pkg::ADDR_W-1:0] addr;
		logic [fwd_pkg::WORD_W-1:0] word;
		logic [fwd_pkg::REP_W-1:0]  reps;
		logic                       beyond;
	} write_cmd_t;

	typedef struct packed {
		logic [fwd_pkg::BYTE_W-1:0] b;
		logic                       s;
	} chunk_item_t;

	// One row of the directed table: a byte, its start mark, and when the
	// write it causes is obvious, that write typed in by hand.
	typedef struct packed {
		logic [fwd_pkg::BYTE_W-1:0] b;
		logic                       s;
		logic                       typed;
		write_cmd_t                 cmd;
	} directed_row_t;

	localparam write_cmd_t NO_WRITE = '0;

	// Three lines with pitch 320, the first byte without a start mark so the
	// parser runs straight from reset. Line one has a single literal word at
	// address zero, line two has a zero packet count, line three skips two
	// rows further down (row 4), shows both ignored opcode classes and one packet
	// with column skip 255 and the longest run, 128 words. The parser then
	// idles, ignores a byte, and a new chunk with a negative line count idles.
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{8'h03, 1'b0, 1'b0, NO_WRITE},
		'{8'h00, 1'b0, 1'b0, NO_WRITE},
		'{8'h01, 1'b0, 1'b0, NO_WRITE},
		'{8'h00, 1'b0, 1'b0, NO_WRITE},
		'{8'h00, 1'b0, 1'b0, NO_WRITE},
		'{8'h01, 1'b0, 1'b0, NO_WRITE},
		'{8'h34, 1'b0, 1'b0, NO_WRITE},
		'{8'h12, 1'b0, 1'b1, '{20'd0, 16'h1234, 8'd1, 1'b0}},
		'{8'h00, 1'b0, 1'b0, NO_WRITE},
		'{8'h00, 1'b0, 1'b0, NO_WRITE},
		'{8'hFE, 1'b0, 1'b0, NO_WRITE},
		'{8'hFF, 1'b0, 1'b0, NO_WRITE},
		'{8'h00, 1'b0, 1'b0, NO_WRITE},
		'{8'h40, 1'b0, 1'b0, NO_WRITE},
		'{8'h00, 1'b0, 1'b0, NO_WRITE},
		'{8'h80, 1'b0, 1'b0, NO_WRITE},
		'{8'h01, 1'b0, 1'b0, NO_WRITE},
		'{8'h00, 1'b0, 1'b0, NO_WRITE},
		'{8'hFF, 1'b0, 1'b0, NO_WRITE},
		'{8'h80, 1'b0, 1'b0, NO_WRITE},
		'{8'hFF, 1'b0, 1'b0, NO_WRITE},
		'{8'hFF, 1'b0, 1'b1, '{20'd1535, 16'hFFFF, 8'd128, 1'b0}},
		'{8'hAA, 1'b0, 1'b0, NO_WRITE},
		'{8'h00, 1'b1, 1'b0, NO_WRITE},
		'{8'h80, 1'b0, 1'b0, NO_WRITE}
	};

	logic clk;
	logic arst_n;

	fwd_chunk_if chunk_ch ();
	fwd_cfg_if   cfg_ch ();
	fwd_write_if wr_ch ();

	flic_word_delta_decoder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chunk  (chunk_ch),
		.cfg    (cfg_ch),
		.wr     (wr_ch)
	);

	// Model state: the parser registers and the pitch register.
	parse_phase_t                  p_phase;
	logic [15:0]                   p_lines;
	logic [13:0]                   p_packets;
	logic [15:0]                   p_col;
	logic [15:0]                   p_row;
	logic [6:0]                    p_lits;
	logic [7:0]                    p_reps;
	logic [7:0]                    p_low;
	logic [fwd_pkg::PITCH_W-1:0]   pitch;

	write_cmd_t  expected_writes[$];
	chunk_item_t chunk_bytes[$];

	int cycle_count   = 0;
	int bytes_sent    = 0;
	int writes_seen   = 0;
	int mismatches    = 0;
	int unexpected    = 0;
	int send_gap_max  = 0;
	int recv_gap_max  = 0;
	int pitch_writes  = 0;
	bit hold_armed    = 0;
	int hold_after    = 0;

	always #5 clk = ~clk;

	// The watchdog ends a run that hangs, for example on a lost write.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("flic_word_delta_decoder_top verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------------

	function automatic void clear_parse_state();
		p_phase   = WAIT_LINES_LO;
		p_lines   = '0;
		p_packets = '0;
		p_col     = '0;
		p_row     = '0;
		p_lits    = '0;
		p_reps    = '0;
		p_low     = '0;
	endfunction

	// A line ends: move down one row, back to column zero, and either read the
	// next line's opcodes or go idle after the last line.
	function automatic void finish_line();
		p_row   = p_row + 16'd1;
		p_col   = '0;
		p_lines = p_lines - 16'd1;
		p_phase = (p_lines == 16'd0) ? PARSE_IDLE : WAIT_OP_LO;
	endfunction

	function automatic void finish_packet();
		p_packets = p_packets - 14'd1;
		if (p_packets == 14'd0) begin
			finish_line();
		end else begin
			p_phase = WAIT_SKIP;
		end
	endfunction

	// The address is formed at full width; the overrun flag uses that full
	// value while the command carries only its low 20 bits.
	function automatic write_cmd_t make_write(input logic [15:0] word, input logic [7:0] reps);
		logic [63:0] full;
		write_cmd_t  c;
		full     = 64'(p_row) * 64'(pitch) + 64'(p_col);
		c.addr   = full[fwd_pkg::ADDR_W-1:0];
		c.word   = word;
		c.reps   = reps;
		c.beyond = (full + 64'(reps) * 64'd2) > 64'(FRAME_LIMIT);
		p_col    = p_col + {7'd0, reps, 1'b0};
		return c;
	endfunction

	task automatic predict_byte(input logic [7:0] b, input logic s, output bit got,
		output write_cmd_t cmd);
		logic [15:0] w;
		got = 1'b0;
		cmd = NO_WRITE;
		if (s) begin
			clear_parse_state();
		end
		w = {b, p_low};
		case (p_phase)
			WAIT_LINES_LO: begin
				p_low   = b;
				p_phase = WAIT_LINES_HI;
			end
			WAIT_OP_LO: begin
				p_low   = b;
				p_phase = WAIT_OP_HI;
			end
			WAIT_LIT_LO: begin
				p_low   = b;
				p_phase = WAIT_LIT_HI;
			end
			WAIT_REP_LO: begin
				p_low   = b;
				p_phase = WAIT_REP_HI;
			end
			WAIT_LINES_HI: begin
				if (w == 16'd0 || w[15]) begin
					p_lines = '0;
					p_phase = PARSE_IDLE;
				end else begin
					p_lines = w;
					p_col   = '0;
					p_phase = WAIT_OP_LO;
				end
			end
			WAIT_OP_HI: begin
				if ((w & OP_CLASS_MASK) == OP_LINE_SKIP) begin
					// The opcode is a negative row delta; subtracting it moves down.
					p_row   = p_row - w;
					p_phase = WAIT_OP_LO;
				end else if ((w & OP_CLASS_MASK) != 16'd0) begin
					p_phase = WAIT_OP_LO;
				end else if (w == 16'd0) begin
					finish_line();
				end else begin
					p_packets = w[13:0];
					p_phase   = WAIT_SKIP;
				end
			end
			WAIT_SKIP: begin
				p_col   = p_col + 16'(b);
				p_phase = WAIT_COUNT;
			end
			WAIT_COUNT: begin
				if (b == 8'd0) begin
					finish_packet();
				end else if (b[7]) begin
					p_reps  = 8'd0 - b;
					p_phase = WAIT_REP_LO;
				end else begin
					p_lits  = b[6:0];
					p_phase = WAIT_LIT_LO;
				end
			end
			WAIT_LIT_HI: begin
				cmd    = make_write(w, 8'd1);
				got    = 1'b1;
				p_lits = p_lits - 7'd1;
				if (p_lits == 7'd0) begin
					finish_packet();
				end else begin
					p_phase = WAIT_LIT_LO;
				end
			end
			WAIT_REP_HI: begin
				cmd    = make_write(w, p_reps);
				got    = 1'b1;
				p_reps = '0;
				finish_packet();
			end
			default: begin
				p_phase = PARSE_IDLE;
			end
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Chunk channel driver
	// ------------------------------------------------------------------------

	// Offers one byte after a random gap and holds it until the transaction.
	// Valid stays high across back-to-back bytes, so it is only lowered when a
	// gap is actually drawn.
	task automatic send_byte(input logic [7:0] b, input logic s, input bit typed,
		input write_cmd_t typed_cmd);
		int         gap;
		bit         got;
		write_cmd_t cmd;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			chunk_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chunk_ch.valid       <= 1'b1;
		chunk_ch.chunk_byte  <= b;
		chunk_ch.chunk_start <= s;
		do @(posedge clk); while (!chunk_ch.ready);
		predict_byte(b, s, got, cmd);
		if (typed) begin
			expected_writes.push_back(typed_cmd);
		end else if (got) begin
			expected_writes.push_back(cmd);
		end
		bytes_sent++;
	endtask

	function automatic void push_word(input logic [15:0] w, input logic first);
		chunk_bytes.push_back('{w[7:0], first});
		chunk_bytes.push_back('{w[15:8], 1'b0});
	endfunction

	function automatic int pick_gap_max();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 3;
			default: return 15;
		endcase
	endfunction

	// Builds one chunk into the byte queue. Most chunks are well formed with a
	// few lines and packets of random content; some are cut short by the next
	// chunk's start mark, and some are replaced by noise bytes. The long line
	// variant has enough maximal packets to wrap the column past 65535.
	task automatic build_chunk(input bit long_line);
		int          n_lines;
		int          n_ops;
		int          n_pk;
		int          n_lit;
		int          keep;
		logic [15:0] line_word;
		logic [15:0] op;
		logic [7:0]  cnt;
		chunk_item_t tmp[$];
		if (!long_line && $urandom_range(0, 19) == 0) begin
			// Noise: random bytes, now and then with a start mark.
			repeat ($urandom_range(1, 8)) begin
				chunk_bytes.push_back('{8'($urandom),
					1'($urandom_range(0, 7) == 0)});
			end
			return;
		end
		if (long_line) begin
			n_lines   = 1;
			line_word = 16'd1;
		end else begin
			case ($urandom_range(0, 19))
				0:       line_word = 16'd0;
				1:       line_word = 16'h8000 | 16'($urandom);
				2:       line_word = 16'hFFFF;
				3:       line_word = 16'($urandom);
				default: line_word = 16'($urandom_range(1, 4));
			endcase
			n_lines = (line_word == 16'd0 || line_word[15]) ? 0 :
				((line_word > 16'd4) ? $urandom_range(1, 4) : int'(line_word));
		end
		push_word(line_word, 1'b1);
		for (int ln = 0; ln < n_lines; ln++) begin
			n_ops = long_line ? 0 : $urandom_range(0, 2);
			for (int k = 0; k < n_ops; k++) begin
				case ($urandom_range(0, 3))
					0:       op = OP_LINE_SKIP | 16'($urandom_range(0, 16'h3FFF));
					1:       op = OP_IGNORED_LO | 16'($urandom_range(0, 16'h3FFF));
					2:       op = OP_IGNORED_HI | 16'($urandom_range(0, 16'h3FFF));
					default: op = 16'hFFFF - 16'($urandom_range(0, 20));
				endcase
				push_word(op, 1'b0);
			end
			if (long_line) begin
				n_pk = 130;
			end else begin
				n_pk = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
			end
			push_word(16'(n_pk), 1'b0);
			for (int p = 0; p < n_pk; p++) begin
				if (long_line) begin
					chunk_bytes.push_back('{8'hFF, 1'b0});
					cnt = 8'h80;
				end else begin
					chunk_bytes.push_back('{8'($urandom), 1'b0});
					case ($urandom_range(0, 19))
						0, 1, 2:     cnt = 8'd0;
						3:           cnt = 8'($urandom_range(1, 127));
						4, 5, 6, 7,
						8, 9, 10:    cnt = 8'($urandom_range(1, 4));
						default:     cnt = 8'(256 - $urandom_range(1, 128));
					endcase
				end
				chunk_bytes.push_back('{cnt, 1'b0});
				if (cnt != 8'd0) begin
					n_lit = cnt[7] ? 1 : int'(cnt);
					for (int i = 0; i < n_lit; i++) begin
						push_word(16'($urandom), 1'b0);
					end
				end
			end
		end
		// A broken chunk loses its tail; the next start mark recovers.
		if (!long_line && $urandom_range(0, 9) == 0 && chunk_bytes.size() > 1) begin
			keep = $urandom_range(1, chunk_bytes.size() - 1);
			tmp  = chunk_bytes[0:keep-1];
			chunk_bytes = tmp;
		end
	endtask

	// ------------------------------------------------------------------------
	// Configuration and phase control
	// ------------------------------------------------------------------------

	task automatic write_pitch(input logic [fwd_pkg::PITCH_W-1:0] v);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.line_pitch <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		pitch = v;
		pitch_writes++;
	endtask

	// Wait until every expected write has come, then let the pipeline settle,
	// since the last bytes of a phase may cause no write at all.
	task automatic drain_writes();
		chunk_ch.valid <= 1'b0;
		while (expected_writes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Write channel receiver and checker
	// ------------------------------------------------------------------------

	// For every write the receiver draws a stall; once per run, when armed,
	// it holds ready low for a long stretch while the sender keeps offering
	// bytes, so the pipeline fills and the chunk channel backs up.
	initial begin : receiver
		int         gap;
		write_cmd_t got_cmd;
		write_cmd_t exp_cmd;
		wr_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = $urandom_range(0, recv_gap_max);
			if (hold_armed && writes_seen >= hold_after) begin
				hold_armed = 1'b0;
				gap        = HOLD_CYCLES;
			end
			if (gap > 0) begin
				wr_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			wr_ch.ready <= 1'b1;
			do @(posedge clk); while (!wr_ch.valid);
			got_cmd = '{wr_ch.write_address, wr_ch.pixel_pair, wr_ch.word_repeat,
				wr_ch.beyond_frame};
			writes_seen++;
			if (expected_writes.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= MAX_REPORTS) begin
					$display("[%0t] unexpected write: addr %h word %h rep %0d beyond %b",
						$realtime, got_cmd.addr, got_cmd.word, got_cmd.reps,
						got_cmd.beyond);
				end
			end else begin
				exp_cmd = expected_writes.pop_front();
				if (got_cmd.addr !== exp_cmd.addr || got_cmd.word !== exp_cmd.word ||
					got_cmd.reps !== exp_cmd.reps ||
					got_cmd.beyond !== exp_cmd.beyond) begin
					mismatches++;
					if (mismatches + unexpected <= MAX_REPORTS) begin
						$display("[%0t] write mismatch: expected addr %h word %h rep %0d beyond %b",
							$realtime, exp_cmd.addr, exp_cmd.word, exp_cmd.reps,
							exp_cmd.beyond);
						$display("[%0t]                 actual   addr %h word %h rep %0d beyond %b",
							$realtime, got_cmd.addr, got_cmd.word, got_cmd.reps,
							got_cmd.beyond);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------

	initial begin : main_seq
		logic [fwd_pkg::PITCH_W-1:0] phase_pitch [NUM_PHASES];
		chunk_item_t                 item;
		int                          phase_start;
		clk                  = 1'b0;
		arst_n               = 1'b0;
		chunk_ch.valid       = 1'b0;
		chunk_ch.chunk_byte  = '0;
		chunk_ch.chunk_start = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.line_pitch    = '0;
		pitch                = fwd_pkg::PITCH_RESET;
		clear_parse_state();

		// The single reset of the run.
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at the reset pitch, with full idling on both sides.
		send_gap_max = 15;
		recv_gap_max = 15;
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_byte(DIRECTED[i].b, DIRECTED[i].s, DIRECTED[i].typed, DIRECTED[i].cmd);
		end
		drain_writes();

		// Random phases: zero pitch, the smallest and largest pitches, the top
		// of the nominal range, a typical pitch, and one drawn at random.
		phase_pitch = '{12'd0, 12'd1, 12'd4095, 12'd2048, 12'd640,
			12'($urandom_range(1, 4095))};
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_pitch(phase_pitch[ph]);
			send_gap_max = pick_gap_max();
			recv_gap_max = pick_gap_max();
			if (ph == 1) begin
				// Back-to-back bytes while the receiver stalls for a long time.
				send_gap_max = 0;
				hold_after   = writes_seen + 5;
				hold_armed   = 1'b1;
			end
			phase_start = bytes_sent;
			if (ph == 0) begin
				build_chunk(1'b1);
			end
			while (bytes_sent - phase_start < PHASE_BYTES || chunk_bytes.size() != 0) begin
				if (chunk_bytes.size() == 0) begin
					build_chunk(1'b0);
				end
				item = chunk_bytes.pop_front();
				send_byte(item.b, item.s, 1'b0, NO_WRITE);
			end
			drain_writes();
		end

		$display("Run sent %0d chunk bytes and checked %0d write commands.",
			bytes_sent, writes_seen);
		$display("Line pitch was written %0d times, covering zero, one and 4095.",
			pitch_writes);
		if (mismatches == 0 && unexpected == 0 && expected_writes.size() == 0) begin
			$display("flic_word_delta_decoder_top verification clean");
		end else begin
			$display("Mismatches %0d, unexpected writes %0d, missing writes %0d.",
				mismatches, unexpected, expected_writes.size());
			$display("flic_word_delta_decoder_top verification failed");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/fwd_pkg.sv
hdl/fwd_chunk_if.sv
hdl/fwd_write_if.sv
hdl/fwd_cfg_if.sv
hdl/flic_word_delta_decoder_top.sv
tb/tb.sv
